@@ hw/rtl/usb_cds_pkg.sv @@
// Package for the USB configuration descriptor scanner.
// Holds descriptor codes, error codes and the result beat layout; no dependencies.
package usb_cds_pkg;

  localparam logic [7:0] DESC_TYPE_INTERFACE = 8'h04;
  localparam logic [7:0] DESC_TYPE_ENDPOINT  = 8'h05;
  localparam logic [7:0] EP_XFER_MASK        = 8'h03;
  localparam logic [7:0] EP_XFER_BULK        = 8'h02;
  localparam logic [7:0] EP_DIR_IN           = 8'h80;
  localparam logic [7:0] INTF_MIN_LEN        = 8'd9;
  localparam logic [7:0] EP_MIN_LEN          = 8'd7;
  localparam logic [7:0] DESC_MIN_LEN        = 8'd2;
  localparam logic [7:0] CLASS_RESET         = 8'hFF;

  // byte offsets inside one descriptor
  localparam logic [7:0] OFS_LENGTH = 8'd0;
  localparam logic [7:0] OFS_TYPE   = 8'd1;
  localparam logic [7:0] OFS_FIRST  = 8'd2;
  localparam logic [7:0] OFS_SECOND = 8'd3;
  localparam logic [7:0] OFS_SIZE_L = 8'd4;
  localparam logic [7:0] OFS_SIZE_H = 8'd5;

  localparam int RESULT_W = 72;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_SHORT_LEN = 2'd1,
    ERR_OVERRUN   = 2'd2
  } parse_err_t;

  // packed from the MSB down; intf_found lands in bit 0
  typedef struct packed {
    logic [3:0]  pad;
    parse_err_t  parse_error;
    logic        usable;
    logic [15:0] out_packet_size;
    logic [7:0]  out_endpoint;
    logic [15:0] in_packet_size;
    logic [7:0]  in_endpoint;
    logic [7:0]  alt_setting;
    logic [7:0]  intf_number;
    logic        intf_found;
  } scan_result_t;

endpackage

@@ hw/rtl/usb_cds_parser.sv @@
// Descriptor walker: byte offset tracking, field capture and commit, summary on last beat.
// Depends on usb_cds_pkg.
module usb_cds_parser
  import usb_cds_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_class,
  input  logic         byte_accept,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output logic         res_valid,
  output scan_result_t res_data
);

  logic [7:0]  wanted_class_r;
  logic [7:0]  byte_offset_r, byte_offset_nxt;
  logic [7:0]  desc_length_r, desc_length_nxt;
  logic [7:0]  desc_type_r, desc_type_nxt;
  logic        class_match_r, class_match_nxt;
  logic        halted_r, halted_nxt;
  logic [7:0]  pend_first_r, pend_first_nxt;
  logic [7:0]  pend_second_r, pend_second_nxt;
  logic [7:0]  pend_class_r, pend_class_nxt;
  logic [15:0] pend_size_r, pend_size_nxt;
  logic        have_intf_r, have_intf_nxt;
  logic [7:0]  chosen_intf_r, chosen_intf_nxt;
  logic [7:0]  chosen_alt_r, chosen_alt_nxt;
  logic [7:0]  in_ep_r, in_ep_nxt;
  logic [15:0] in_size_r, in_size_nxt;
  logic [7:0]  out_ep_r, out_ep_nxt;
  logic [15:0] out_size_r, out_size_nxt;
  parse_err_t  err_r, err_nxt;
  logic        ep_bulk, ep_dir_in;

  always_comb begin
    byte_offset_nxt = byte_offset_r;
    desc_length_nxt = desc_length_r;
    desc_type_nxt   = desc_type_r;
    class_match_nxt = class_match_r;
    halted_nxt      = halted_r;
    pend_first_nxt  = pend_first_r;
    pend_second_nxt = pend_second_r;
    pend_class_nxt  = pend_class_r;
    pend_size_nxt   = pend_size_r;
    have_intf_nxt   = have_intf_r;
    chosen_intf_nxt = chosen_intf_r;
    chosen_alt_nxt  = chosen_alt_r;
    in_ep_nxt       = in_ep_r;
    in_size_nxt     = in_size_r;
    out_ep_nxt      = out_ep_r;
    out_size_nxt    = out_size_r;
    err_nxt         = err_r;
    res_valid       = 1'b0;
    res_data        = '0;
    ep_bulk         = 1'b0;
    ep_dir_in       = 1'b0;

    if (byte_accept) begin
      if (!halted_r) begin
        if (byte_offset_r == OFS_LENGTH) begin
          // a lone final byte never starts a descriptor
          if (!last_byte) begin
            if (data_byte < DESC_MIN_LEN) begin
              err_nxt    = ERR_SHORT_LEN;
              halted_nxt = 1'b1;
            end else begin
              desc_length_nxt = data_byte;
              pend_first_nxt  = '0;
              pend_second_nxt = '0;
              pend_class_nxt  = '0;
              pend_size_nxt   = '0;
              byte_offset_nxt = OFS_TYPE;
            end
          end
        end else begin
          case (byte_offset_r)
            OFS_TYPE:   desc_type_nxt = data_byte;
            OFS_FIRST:  pend_first_nxt = data_byte;
            OFS_SECOND: pend_second_nxt = data_byte;
            OFS_SIZE_L: pend_size_nxt = {pend_size_r[15:8], data_byte};
            OFS_SIZE_H: begin
              pend_class_nxt = data_byte;
              pend_size_nxt  = {data_byte, pend_size_r[7:0]};
            end
            default: ;
          endcase

          if ({1'b0, byte_offset_r} + 9'd1 == {1'b0, desc_length_r}) begin
            byte_offset_nxt = OFS_LENGTH;
            ep_bulk   = (pend_second_nxt & EP_XFER_MASK) == EP_XFER_BULK;
            ep_dir_in = (pend_first_nxt & EP_DIR_IN) != 8'd0;
            if (desc_type_nxt == DESC_TYPE_INTERFACE && desc_length_r >= INTF_MIN_LEN) begin
              class_match_nxt = (pend_class_nxt == wanted_class_r);
              if (class_match_nxt && !have_intf_r) begin
                have_intf_nxt   = 1'b1;
                chosen_intf_nxt = pend_first_nxt;
                chosen_alt_nxt  = pend_second_nxt;
              end
            end else if (desc_type_nxt == DESC_TYPE_ENDPOINT &&
                         desc_length_r >= EP_MIN_LEN) begin
              if (class_match_r && ep_bulk) begin
                if (ep_dir_in) begin
                  if (in_ep_r == 8'd0) begin
                    in_ep_nxt   = pend_first_nxt;
                    in_size_nxt = pend_size_nxt;
                  end
                end else if (out_ep_r == 8'd0) begin
                  // address zero is kept but still counts as missing
                  out_ep_nxt   = pend_first_nxt;
                  out_size_nxt = pend_size_nxt;
                end
              end
            end
          end else begin
            if (last_byte) begin
              err_nxt = ERR_OVERRUN;
            end
            byte_offset_nxt = byte_offset_r + 8'd1;
          end
        end
      end

      if (last_byte) begin
        res_valid                = 1'b1;
        res_data.intf_found      = have_intf_nxt;
        res_data.intf_number     = chosen_intf_nxt;
        res_data.alt_setting     = chosen_alt_nxt;
        res_data.in_endpoint     = in_ep_nxt;
        res_data.in_packet_size  = in_size_nxt;
        res_data.out_endpoint    = out_ep_nxt;
        res_data.out_packet_size = out_size_nxt;
        res_data.usable          = have_intf_nxt && (in_ep_nxt != 8'd0) &&
                                   (out_ep_nxt != 8'd0);
        res_data.parse_error     = err_nxt;
        // frame done: back to the reset picture
        byte_offset_nxt = '0;
        desc_length_nxt = '0;
        desc_type_nxt   = '0;
        class_match_nxt = 1'b0;
        halted_nxt      = 1'b0;
        pend_first_nxt  = '0;
        pend_second_nxt = '0;
        pend_class_nxt  = '0;
        pend_size_nxt   = '0;
        have_intf_nxt   = 1'b0;
        chosen_intf_nxt = '0;
        chosen_alt_nxt  = '0;
        in_ep_nxt       = '0;
        in_size_nxt     = '0;
        out_ep_nxt      = '0;
        out_size_nxt    = '0;
        err_nxt         = ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_class_r <= CLASS_RESET;
      byte_offset_r  <= '0;
      desc_length_r  <= '0;
      desc_type_r    <= '0;
      class_match_r  <= 1'b0;
      halted_r       <= 1'b0;
      pend_first_r   <= '0;
      pend_second_r  <= '0;
      pend_class_r   <= '0;
      pend_size_r    <= '0;
      have_intf_r    <= 1'b0;
      chosen_intf_r  <= '0;
      chosen_alt_r   <= '0;
      in_ep_r        <= '0;
      in_size_r      <= '0;
      out_ep_r       <= '0;
      out_size_r     <= '0;
      err_r          <= ERR_NONE;
    end else begin
      if (cfg_we) begin
        wanted_class_r <= cfg_class;
      end
      byte_offset_r <= byte_offset_nxt;
      desc_length_r <= desc_length_nxt;
      desc_type_r   <= desc_type_nxt;
      class_match_r <= class_match_nxt;
      halted_r      <= halted_nxt;
      pend_first_r  <= pend_first_nxt;
      pend_second_r <= pend_second_nxt;
      pend_class_r  <= pend_class_nxt;
      pend_size_r   <= pend_size_nxt;
      have_intf_r   <= have_intf_nxt;
      chosen_intf_r <= chosen_intf_nxt;
      chosen_alt_r  <= chosen_alt_nxt;
      in_ep_r       <= in_ep_nxt;
      in_size_r     <= in_size_nxt;
      out_ep_r      <= out_ep_nxt;
      out_size_r    <= out_size_nxt;
      err_r         <= err_nxt;
    end
  end

endmodule

@@ hw/rtl/usb_cds_outbuf.sv @@
// Two-entry result buffer (output register plus skid) for the scanner.
// Depends on usb_cds_pkg.
module usb_cds_outbuf
  import usb_cds_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  scan_result_t push_data,
  output logic         space_ok,
  output logic         out_valid,
  input  logic         out_ready,
  output scan_result_t out_data
);

  logic         main_valid_r, main_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  scan_result_t main_r, main_nxt;
  scan_result_t skid_r, skid_nxt;
  logic         pop;

  assign pop       = main_valid_r && out_ready;
  assign space_ok  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // push only arrives while the skid entry is free
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_data;
      end
    end else if (!main_valid_r) begin
      main_valid_nxt = push;
      main_nxt       = push_data;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

@@ hw/rtl/usb_config_descriptor_scanner_core.sv @@
// Scans a USB configuration descriptor set, one byte per in_ beat with tlast on the
// final byte, and returns one summary beat per set: the first interface of the class
// in cfg_data, the first bulk IN and OUT endpoints under that class, and a parse
// error code. A byte is taken every cycle while the result skid entry is free; the
// walker updates its state in the cycle the beat is accepted. A two-entry result
// buffer keeps input flowing while a summary waits on out_tready. Write cfg_data only
// between sets. Depends on usb_cds_pkg, usb_cds_parser and usb_cds_outbuf.
module usb_config_descriptor_scanner_core
  import usb_cds_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,   // wanted_class
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // data_byte
  input  logic                in_tlast,   // last_byte
  output logic                out_tvalid,
  input  logic                out_tready,
  // [0] intf_found, [8:1] intf_number, [16:9] alt_setting, [24:17] in_endpoint,
  // [40:25] in_packet_size, [48:41] out_endpoint, [64:49] out_packet_size,
  // [65] usable, [67:66] parse_error, [71:68] zero
  output logic [RESULT_W-1:0] out_tdata
);

  logic         byte_accept;
  logic         res_valid;
  scan_result_t res_data;
  scan_result_t buf_data;
  logic         space_ok;

  assign cfg_ready   = 1'b1;
  assign in_tready   = space_ok;
  assign byte_accept = in_tvalid && in_tready;

  usb_cds_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_class   (cfg_data),
    .byte_accept (byte_accept),
    .data_byte   (in_tdata),
    .last_byte   (in_tlast),
    .res_valid   (res_valid),
    .res_data    (res_data)
  );

  usb_cds_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (buf_data)
  );

  assign out_tdata = buf_data;

endmodule

@@ hw/rtl/usb_cds_checker.sv @@
// Port-level checks for the descriptor scanner, bound to the top level.
// Depends on usb_config_descriptor_scanner_core ports only.
module usb_cds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[67:66] != 2'd3 && out_tdata[71:68] == 4'd0)
    else $error("bad error code or padding");

  a_usable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65] |->
      out_tdata[0] && out_tdata[24:17] != 8'd0 && out_tdata[48:41] != 8'd0)
    else $error("usable without interface and both endpoints");

  a_no_intf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |->
      out_tdata[8:1] == 8'd0 && out_tdata[16:9] == 8'd0 && out_tdata[24:17] == 8'd0)
    else $error("interface fields set without a chosen interface");

  a_ep_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[24:17] == 8'd0 || out_tdata[24]) && !out_tdata[48])
    else $error("endpoint direction bit mismatch");

endmodule

bind usb_config_descriptor_scanner_core usb_cds_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ dv/usb_cds_summary_checker.sv @@
// Checker for the USB configuration descriptor scanner: watches cfg, in_ and out_ beats,
// predicts the summary beat of each descriptor set and compares it field by field.
// Depends on usb_cds_pkg for codes and the result layout.
`timescale 1ns / 100ps

module usb_cds_summary_checker
  import usb_cds_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [RESULT_W-1:0] out_tdata,
  output int                  mismatches,
  output int                  summaries_due
);

  logic [7:0]  wanted_class;

  // descriptor walker state
  logic [7:0]  walk_ofs;
  logic [7:0]  desc_len;
  logic [7:0]  desc_kind;
  logic [7:0]  fld_a;
  logic [7:0]  fld_b;
  logic [7:0]  fld_class;
  logic [15:0] fld_size;
  logic        class_hit;
  logic        stopped;
  logic        intf_taken;
  logic [7:0]  intf_num;
  logic [7:0]  intf_alt;
  logic [7:0]  bulk_in_addr;
  logic [15:0] bulk_in_size;
  logic [7:0]  bulk_out_addr;
  logic [15:0] bulk_out_size;
  parse_err_t  walk_err;

  scan_result_t summary_q[$];

  initial begin
    mismatches    = 0;
    summaries_due = 0;
  end

  task clear_walk();
    walk_ofs      = OFS_LENGTH;
    desc_len      = '0;
    desc_kind     = '0;
    fld_a         = '0;
    fld_b         = '0;
    fld_class     = '0;
    fld_size      = '0;
    class_hit     = 1'b0;
    stopped       = 1'b0;
    intf_taken    = 1'b0;
    intf_num      = '0;
    intf_alt      = '0;
    bulk_in_addr  = '0;
    bulk_in_size  = '0;
    bulk_out_addr = '0;
    bulk_out_size = '0;
    walk_err      = ERR_NONE;
  endtask

  task close_descriptor();
    if (desc_kind == DESC_TYPE_INTERFACE && desc_len >= INTF_MIN_LEN) begin
      // every full interface re-arms or disarms endpoint capture
      class_hit = (fld_class == wanted_class);
      if (class_hit && !intf_taken) begin
        intf_taken = 1'b1;
        intf_num   = fld_a;
        intf_alt   = fld_b;
      end
    end else if (desc_kind == DESC_TYPE_ENDPOINT && desc_len >= EP_MIN_LEN) begin
      if (class_hit && (fld_b & EP_XFER_MASK) == EP_XFER_BULK) begin
        if ((fld_a & EP_DIR_IN) != 8'h00) begin
          if (bulk_in_addr == 8'h00) begin
            bulk_in_addr = fld_a;
            bulk_in_size = fld_size;
          end
        end else if (bulk_out_addr == 8'h00) begin
          // address zero is taken but still counts as missing
          bulk_out_addr = fld_a;
          bulk_out_size = fld_size;
        end
      end
    end
  endtask

  task walk_byte(input logic [7:0] b, input logic last);
    if (walk_ofs == OFS_LENGTH) begin
      // a byte that would open a new descriptor on tlast is dropped
      if (!last) begin
        if (b < DESC_MIN_LEN) begin
          walk_err = ERR_SHORT_LEN;
          stopped  = 1'b1;
        end else begin
          desc_len  = b;
          fld_a     = '0;
          fld_b     = '0;
          fld_class = '0;
          fld_size  = '0;
          walk_ofs  = OFS_TYPE;
        end
      end
    end else begin
      case (walk_ofs)
        OFS_TYPE:   desc_kind = b;
        OFS_FIRST:  fld_a = b;
        OFS_SECOND: fld_b = b;
        OFS_SIZE_L: fld_size[7:0] = b;
        OFS_SIZE_H: begin
          fld_class      = b;
          fld_size[15:8] = b;
        end
        default: ;
      endcase
      if ({1'b0, walk_ofs} + 9'd1 == {1'b0, desc_len}) begin
        close_descriptor();
        walk_ofs = OFS_LENGTH;
      end else begin
        if (last) walk_err = ERR_OVERRUN;
        walk_ofs = walk_ofs + 8'd1;
      end
    end
  endtask

  function automatic scan_result_t make_summary();
    scan_result_t s;
    s.pad             = '0;
    s.parse_error     = walk_err;
    s.usable          = intf_taken && bulk_in_addr != 8'h00 && bulk_out_addr != 8'h00;
    s.out_packet_size = bulk_out_size;
    s.out_endpoint    = bulk_out_addr;
    s.in_packet_size  = bulk_in_size;
    s.in_endpoint     = bulk_in_addr;
    s.alt_setting     = intf_alt;
    s.intf_number     = intf_num;
    s.intf_found      = intf_taken;
    return s;
  endfunction

  task check_field(input string name, input logic [15:0] want, input logic [15:0] seen);
    if (want !== seen) begin
      mismatches++;
      $display("%0t: summary %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    scan_result_t seen_sum;
    scan_result_t want_sum;
    if (!rst_n) begin
      wanted_class = CLASS_RESET;
      clear_walk();
      summary_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) wanted_class = cfg_data;
      if (in_tvalid && in_tready) begin
        if (!stopped) walk_byte(in_tdata, in_tlast);
        if (in_tlast) begin
          summary_q.push_back(make_summary());
          clear_walk();
        end
      end
      if (out_tvalid && out_tready) begin
        seen_sum = out_tdata;
        if (summary_q.size() == 0) begin
          mismatches++;
          $display("%0t: summary beat with none expected, expected nothing, actual %0h",
                   $time, out_tdata);
        end else begin
          want_sum = summary_q.pop_front();
          check_field("intf_found", want_sum.intf_found, seen_sum.intf_found);
          check_field("intf_number", want_sum.intf_number, seen_sum.intf_number);
          check_field("alt_setting", want_sum.alt_setting, seen_sum.alt_setting);
          check_field("in_endpoint", want_sum.in_endpoint, seen_sum.in_endpoint);
          check_field("in_packet_size", want_sum.in_packet_size, seen_sum.in_packet_size);
          check_field("out_endpoint", want_sum.out_endpoint, seen_sum.out_endpoint);
          check_field("out_packet_size", want_sum.out_packet_size,
                      seen_sum.out_packet_size);
          check_field("usable", want_sum.usable, seen_sum.usable);
          check_field("parse_error", want_sum.parse_error, seen_sum.parse_error);
          check_field("pad", want_sum.pad, seen_sum.pad);
        end
      end
    end
    summaries_due = summary_q.size();
  end

endmodule

@@ dv/usb_config_descriptor_scanner_core_test.sv @@
// Testbench top for usb_config_descriptor_scanner_core: builds descriptor sets, drives
// cfg and in_ beats, throttles out_ and gives the verdict.
// Depends on usb_cds_pkg, the scanner RTL and usb_cds_summary_checker.
`timescale 1ns / 100ps

module usb_config_descriptor_scanner_core_test;
  import usb_cds_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 800;
  localparam int SEGMENTS     = 6;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [7:0] DESC_TYPE_CONFIG = 8'h02;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_data = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [RESULT_W-1:0] out_tdata;

  int mismatches;
  int summaries_due;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int sets_sent = 0;
  logic [7:0] cur_class = CLASS_RESET;
  logic [7:0] set_bytes[$];

  usb_config_descriptor_scanner_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  usb_cds_summary_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatches    (mismatches),
    .summaries_due (summaries_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("usb_config_descriptor_scanner_core_test failed");
      $finish;
    end
  end

  // out_ side: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  task set_idle_mode(input int mode);
    case (mode)
      0: begin in_idle_pct = 13; out_stall_pct = 54; end
      1: begin in_idle_pct = 54; out_stall_pct = 13; end
      default: begin in_idle_pct = 0; out_stall_pct = 0; end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after the beat
  task send_byte(input logic [7:0] b, input logic last);
    // each cycle idles with the set odds
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task send_set();
    for (int i = 0; i < set_bytes.size(); i++) send_byte(set_bytes[i], i == set_bytes.size() - 1);
    sets_sent++;
  endtask

  // write the class register once the walker and result path are quiet
  task write_class(input logic [7:0] cls);
    in_tvalid <= 1'b0;
    while (summaries_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cls;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_class = cls;
  endtask

  task add_desc(input logic [7:0] len, input logic [7:0] kind, input logic [7:0] b2,
                input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5);
    set_bytes.push_back(len);
    set_bytes.push_back(kind);
    for (int i = 2; i < len; i++) begin
      case (i)
        2: set_bytes.push_back(b2);
        3: set_bytes.push_back(b3);
        4: set_bytes.push_back(b4);
        5: set_bytes.push_back(b5);
        default: set_bytes.push_back(8'($urandom_range(255)));
      endcase
    end
  endtask

  function automatic logic [7:0] pick_len(input int nominal);
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'($urandom_range(2, nominal - 1));
    if (roll < 20) return 8'($urandom_range(nominal + 1, nominal + 6));
    return 8'(nominal);
  endfunction

  task add_interface();
    logic [7:0] cls;
    cls = ($urandom_range(99) < 60) ? cur_class : 8'($urandom_range(255));
    add_desc(pick_len(9), DESC_TYPE_INTERFACE, 8'($urandom_range(255)),
             8'($urandom_range(3)), 8'($urandom_range(4)), cls);
  endtask

  task add_endpoint();
    logic [7:0]  addr;
    logic [7:0]  attr;
    logic [15:0] size;
    int          roll;
    roll = $urandom_range(99);
    if (roll < 6)       addr = 8'h00;
    else if (roll < 16) addr = 8'($urandom_range(255));
    else                addr = {1'($urandom_range(1)), 3'b000, 4'($urandom_range(15))};
    attr = ($urandom_range(99) < 75) ? {6'($urandom_range(63)), 2'b10}
                                     : 8'($urandom_range(255));
    case ($urandom_range(4))
      0: size = 16'd8;
      1: size = 16'd64;
      2: size = 16'd512;
      3: size = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
      default: size = 16'($urandom_range(65535));
    endcase
    add_desc(pick_len(7), DESC_TYPE_ENDPOINT, addr, attr, size[7:0], size[15:8]);
  endtask

  task build_good_set();
    int roll;
    set_bytes.delete();
    add_desc(8'd9, DESC_TYPE_CONFIG, 8'($urandom_range(255)), 8'($urandom_range(255)),
             8'($urandom_range(255)), 8'($urandom_range(255)));
    repeat ($urandom_range(1, 6)) begin
      roll = $urandom_range(99);
      if (roll < 30)      add_interface();
      else if (roll < 75) add_endpoint();
      else if (roll < 93)
        add_desc(($urandom_range(49) == 0) ? 8'd255 : 8'($urandom_range(2, 12)),
                 8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
      else begin
        // length byte of zero or one at a descriptor boundary, then junk
        set_bytes.push_back(8'($urandom_range(1)));
        repeat ($urandom_range(4)) set_bytes.push_back(8'($urandom_range(255)));
      end
    end
    roll = $urandom_range(99);
    if (roll < 12) begin
      repeat ($urandom_range(1, 6)) if (set_bytes.size() > 1) void'(set_bytes.pop_back());
    end else if (roll < 22) begin
      set_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task build_noise_set();
    set_bytes.delete();
    repeat ($urandom_range(1, 16)) set_bytes.push_back(8'($urandom_range(255)));
  endtask

  initial begin
    logic [7:0] seg_class;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed sets
    set_idle_mode(0);
    write_class(8'h08);
    set_bytes = '{8'hA5};
    send_set();
    set_bytes = '{8'h00, 8'hFF};
    send_set();
    set_bytes = '{8'h01, 8'h00};
    send_set();
    set_bytes.delete();
    add_desc(8'd9, DESC_TYPE_INTERFACE, 8'h01, 8'h00, 8'h02, 8'h08);
    add_desc(8'd7, DESC_TYPE_ENDPOINT, 8'h81, 8'h02, 8'h00, 8'h02);
    add_desc(8'd7, DESC_TYPE_ENDPOINT, 8'h02, 8'h02, 8'h40, 8'h00);
    send_set();
    set_bytes = '{8'h05, 8'hFF};
    send_set();

    // random sets over the idle modes and several class settings
    for (int s = 0; s < SEGMENTS; s++) begin
      case (s)
        0: seg_class = 8'h00;
        1: seg_class = 8'hFF;
        2: seg_class = 8'h08;
        4: seg_class = 8'h0A;
        default: seg_class = 8'($urandom_range(255));
      endcase
      write_class(seg_class);
      set_idle_mode(s / 2);
      if (s == 1) begin
        // long out_ hold-off while short sets keep coming
        hold_requests++;
        repeat (16) begin
          if ($urandom_range(1) != 0) set_bytes = '{8'($urandom_range(255))};
          else set_bytes = '{8'($urandom_range(1)), 8'($urandom_range(255))};
          send_set();
        end
      end
      while (bytes_sent < RANDOM_BYTES * (s + 1) / SEGMENTS) begin
        if ($urandom_range(99) < 80) build_good_set();
        else build_noise_set();
        send_set();
      end
    end

    in_tvalid <= 1'b0;
    while (summaries_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("usb_config_descriptor_scanner_core_test passed");
    end else begin
      $display("usb_config_descriptor_scanner_core_test failed");
    end
    $finish;
  end

endmodule
